### rtl/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg
// Shared types and constants for the sorted key list: store depth, key width,
// command and status codes, and the structs passed between the cells.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int DEPTH   = 16;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  // command codes
  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } skl_cmd_t;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // command broadcast to every cell
  typedef struct packed {
    logic                    write;
    skl_cmd_t                op;
    logic signed [KEY_W-1:0] key;
  } skl_bcast_t;

  // flags rippled from a cell to its right neighbor
  typedef struct packed {
    logic after;   // this cell sits at or past the insert position
    logic found;   // a matching key lies at or left of this cell
  } skl_link_t;

endpackage

### rtl/skl_if.sv
// ----------------------------------------------------------------------------
// skl_cmd_if / skl_rsp_if
// Valid/ready channels for command words and response words.
// ----------------------------------------------------------------------------
interface skl_cmd_if
  import skl_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [KEY_W-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface skl_rsp_if
  import skl_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_count, output ready);
endinterface

### rtl/sorted_key_list.sv
// The response word is registered and valid in the cycle after the command is accepted.
// Throughput: one command per cycle while the response is not stalled; every cell compares and shifts in the
// same cycle, limited by the found flag rippling along the row of cells.
// A new command is taken while the previous response is being taken.
// Reset clears the entry count and response valid; key slots are not cleared.
// ----------------------------------------------------------------------------
// sorted_key_list
// Bounded ascending store of signed keys built as a row of cells. Insert
// places a key ahead of equal keys; remove deletes the first equal key.
// ----------------------------------------------------------------------------
module sorted_key_list
  import skl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  skl_cmd_if.sink     cmd_in,
  skl_rsp_if.source   rsp_out
);

  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic                    accept;
  logic                    full;
  logic                    found;
  skl_cmd_t                op;
  skl_bcast_t              bcast;
  logic [STAT_W-1:0]       status_next;
  logic                    rsp_valid;
  logic [STAT_W-1:0]       rsp_status;
  logic [COUNT_W-1:0]      rsp_count;
  logic signed [KEY_W-1:0] cell_key [DEPTH];
  skl_link_t               cell_link [DEPTH];

  // input handshake
  assign cmd_in.ready = !rsp_valid || rsp_out.ready;
  assign accept       = cmd_in.valid && cmd_in.ready;
  assign op           = skl_cmd_t'(cmd_in.command);
  assign full         = (count == CNT_W'(DEPTH));

  assign bcast.write = accept && ((op == CMD_REMOVE) || !full);
  assign bcast.op    = op;
  assign bcast.key   = cmd_in.key;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] l_key;
    skl_link_t               l_link;
    logic signed [KEY_W-1:0] r_key;

    if (i == 0) begin : g_first
      assign l_key  = cmd_in.key;
      assign l_link = '{after: 1'b0, found: 1'b0};
    end else begin : g_mid
      assign l_key  = cell_key[i-1];
      assign l_link = cell_link[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_key = cell_key[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
    end

    skl_cell u_cell (
      .clk       (clk),
      .bcast     (bcast),
      .occupied  (count > CNT_W'(i)),
      .left_key  (l_key),
      .left_link (l_link),
      .right_key (r_key),
      .key       (cell_key[i]),
      .link      (cell_link[i])
    );
  end

  assign found = cell_link[DEPTH-1].found;

  // count and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          status_next = ST_NOT_FOUND;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_out.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // response word register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= status_next;
      rsp_count  <= COUNT_W'(count_next);
    end
  end

  assign rsp_out.valid       = rsp_valid;
  assign rsp_out.status      = rsp_status;
  assign rsp_out.entry_count = rsp_count;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && op == CMD_INSERT && full) |=>
      (rsp_out.valid && rsp_out.status == ST_FULL && $stable(count)))
    else $error("insert into full store not rejected");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (accept && op == CMD_REMOVE && count == '0) |=>
      (rsp_out.valid && rsp_out.status == ST_NOT_FOUND && count == '0))
    else $error("remove from empty store did not report not found");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && op == CMD_INSERT && !full) |=>
      (count == $past(count) + CNT_W'(1) && rsp_out.status == ST_OK))
    else $error("insert did not grow the store");

endmodule

### rtl/skl_cell.sv
// ----------------------------------------------------------------------------
// skl_cell
// One slot of the sorted store. Compares its key against the command key,
// and on a write either keeps its key, takes the new key, takes the key of
// its left neighbor (insert shift) or of its right neighbor (remove shift).
// ----------------------------------------------------------------------------
module skl_cell
  import skl_pkg::*;
(
  input  logic                    clk,
  input  skl_bcast_t              bcast,
  input  logic                    occupied,
  input  logic signed [KEY_W-1:0] left_key,
  input  skl_link_t               left_link,
  input  logic signed [KEY_W-1:0] right_key,
  output logic signed [KEY_W-1:0] key,
  output skl_link_t               link
);

  logic                    less;
  logic                    eq;
  logic signed [KEY_W-1:0] key_next;

  // compare against the command key
  assign less = occupied && (key < bcast.key);
  assign eq   = occupied && (key == bcast.key);

  assign link.after = !less;
  assign link.found = left_link.found | eq;

  // slot update
  always_comb begin
    key_next = key;
    case (bcast.op)
      CMD_INSERT: begin
        if (left_link.after) begin
          key_next = left_key;
        end else if (!less) begin
          key_next = bcast.key;
        end
      end
      CMD_REMOVE: begin
        if (link.found) begin
          key_next = right_key;
        end
      end
      default: key_next = key;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bcast.write) begin
      key <= key_next;
    end
  end

endmodule
